FILE: rtl/core/qpcw_pkg.sv
// Shared types and constants for the quadratic polynomial coordinate warp.
`timescale 1ns / 1ps
`default_nettype none

package qpcw_pkg;

   // Field widths of the streaming channels.
   localparam int PIXEL_W    = 12;
   localparam int REQ_DATA_W = 24;
   localparam int SRC_W      = 32;
   localparam int RSP_DATA_W = 64;

   // Coefficient layout: two 32-bit signed words per 64-bit register.
   localparam int COEF_W     = 32;
   localparam int NUM_LANES  = 2;
   localparam int NUM_REGS   = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   // Accumulator in units of 2^-40, wide enough for all six terms at the
   // widest supported coordinate.
   localparam int SUM_W      = 70;
   localparam int FRAC_SHIFT = 32;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ONE = 3'd0,
      REG_X   = 3'd1,
      REG_Y   = 3'd2,
      REG_XY  = 3'd3,
      REG_XX  = 3'd4,
      REG_YY  = 3'd5
   } reg_index_type;

   // Reset values give the identity mapping.
   localparam logic [CSR_DATA_W-1:0] RESET_ONE = 64'h0000_0000_0000_0000;
   localparam logic [CSR_DATA_W-1:0] RESET_X   = 64'h0000_0000_0100_0000;
   localparam logic [CSR_DATA_W-1:0] RESET_Y   = 64'h0100_0000_0000_0000;
   localparam logic [CSR_DATA_W-1:0] RESET_Q   = 64'h0000_0000_0000_0000;

   localparam logic [SRC_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [SRC_W-1:0] SAT_MIN = 32'h8000_0000;

endpackage : qpcw_pkg

`default_nettype wire

FILE: rtl/core/quadratic_polynomial_coord_warp_top.sv
// Top level: pipelined evaluation of two second-order coordinate polynomials.
//
//   Channel | Direction | Signals                          | Contents
//   req     | in        | req_tvalid/tready/tdata[23:0]    | pixel_x, pixel_y
//   rsp     | out       | rsp_tvalid/tready/tdata[63:0]    | source_x, source_y
//           |           | rsp_tuser[0]                     | overflow
//   csr     | in        | csr_we, csr_index[2:0], csr_wdata| six coefficient pairs
//
// One transaction per cycle while the output is not stalled; a result passes the
// registered stages for products, quadratic products, sum, and round and saturate.
// Each stage carries its own valid bit and fills bubbles, so a stall at the
// output only holds the stages that are occupied up to it.
// Reset is synchronous, clears the valid bits and loads the identity coefficients.
`timescale 1ns / 1ps
`default_nettype none

module quadratic_polynomial_coord_warp_top
   import qpcw_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [11:0] pixel_x, [23:12] pixel_y
   // Result channel.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [31:0] source_x, [63:32] source_y
   output logic                       rsp_tuser,   // [0] overflow
   // Configuration write port.
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // Coordinate bits actually used, and product widths that follow from them.
   localparam int CW    = (COORD_BITS < PIXEL_W) ? COORD_BITS : PIXEL_W;
   localparam int SQ_W  = 2 * CW;
   localparam int LIN_W = COEF_W + CW + 1;
   localparam int QD_W  = COEF_W + SQ_W + 1;
   localparam int RS_W  = SUM_W - FRAC_SHIFT;

   // Select one coefficient word of a register: lane 0 low, lane 1 high.
   function automatic logic signed [COEF_W-1:0] coef_word(
      input logic [CSR_DATA_W-1:0] word,
      input logic                  lane
   );
      coef_word = lane ? $signed(word[CSR_DATA_W-1:COEF_W]) : $signed(word[COEF_W-1:0]);
   endfunction

   // Coefficient registers; the user must write them only while the pipeline is idle (not enforced here).
   logic [CSR_DATA_W-1:0] coef_ff [NUM_REGS];

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[REG_ONE] <= RESET_ONE;
         coef_ff[REG_X]   <= RESET_X;
         coef_ff[REG_Y]   <= RESET_Y;
         coef_ff[REG_XY]  <= RESET_Q;
         coef_ff[REG_XX]  <= RESET_Q;
         coef_ff[REG_YY]  <= RESET_Q;
      end else if (csr_we && (csr_index <= REG_YY)) begin
         coef_ff[csr_index] <= csr_wdata;
      end
   end

   // Pipeline valid bits and stage advance chain.
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_adv, s2_adv, s3_adv, s4_adv;

   assign s4_adv     = !s4_valid_ff || rsp_tready;
   assign s3_adv     = !s3_valid_ff || s4_adv;
   assign s2_adv     = !s2_valid_ff || s3_adv;
   assign s1_adv     = !s1_valid_ff || s2_adv;
   assign req_tready = s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_adv) s1_valid_ff <= req_tvalid;
         if (s2_adv) s2_valid_ff <= s1_valid_ff;
         if (s3_adv) s3_valid_ff <= s2_valid_ff;
         if (s4_adv) s4_valid_ff <= s3_valid_ff;
      end
   end

   // Stage 1: coordinate products and the linear terms of both lanes.
   logic [CW-1:0]           x_in, y_in;
   logic [SQ_W-1:0]         xy1_in, xx1_in, yy1_in;
   logic [SQ_W-1:0]         xy1_ff, xx1_ff, yy1_ff;
   logic signed [LIN_W-1:0] lx1_in [NUM_LANES];
   logic signed [LIN_W-1:0] ly1_in [NUM_LANES];
   logic signed [LIN_W-1:0] lx1_ff [NUM_LANES];
   logic signed [LIN_W-1:0] ly1_ff [NUM_LANES];

   assign x_in   = req_tdata[CW-1:0];
   assign y_in   = req_tdata[PIXEL_W +: CW];
   assign xy1_in = SQ_W'(x_in) * SQ_W'(y_in);
   assign xx1_in = SQ_W'(x_in) * SQ_W'(x_in);
   assign yy1_in = SQ_W'(y_in) * SQ_W'(y_in);

   always_comb begin
      for (int k = 0; k < NUM_LANES; k++) begin
         lx1_in[k] = LIN_W'(coef_word(coef_ff[REG_X], 1'(k)))
                   * LIN_W'($signed({1'b0, x_in}));
         ly1_in[k] = LIN_W'(coef_word(coef_ff[REG_Y], 1'(k)))
                   * LIN_W'($signed({1'b0, y_in}));
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         xy1_ff <= xy1_in;
         xx1_ff <= xx1_in;
         yy1_ff <= yy1_in;
         lx1_ff <= lx1_in;
         ly1_ff <= ly1_in;
      end
   end

   // Stage 2: quadratic terms, and constant plus linear terms in 2^-40 units.
   logic signed [QD_W-1:0]  qxy2_in [NUM_LANES];
   logic signed [QD_W-1:0]  qxx2_in [NUM_LANES];
   logic signed [QD_W-1:0]  qyy2_in [NUM_LANES];
   logic signed [SUM_W-1:0] lin2_in [NUM_LANES];
   logic signed [QD_W-1:0]  qxy2_ff [NUM_LANES];
   logic signed [QD_W-1:0]  qxx2_ff [NUM_LANES];
   logic signed [QD_W-1:0]  qyy2_ff [NUM_LANES];
   logic signed [SUM_W-1:0] lin2_ff [NUM_LANES];

   always_comb begin
      for (int k = 0; k < NUM_LANES; k++) begin
         qxy2_in[k] = QD_W'(coef_word(coef_ff[REG_XY], 1'(k)))
                    * QD_W'($signed({1'b0, xy1_ff}));
         qxx2_in[k] = QD_W'(coef_word(coef_ff[REG_XX], 1'(k)))
                    * QD_W'($signed({1'b0, xx1_ff}));
         qyy2_in[k] = QD_W'(coef_word(coef_ff[REG_YY], 1'(k)))
                    * QD_W'($signed({1'b0, yy1_ff}));
         lin2_in[k] = (SUM_W'(coef_word(coef_ff[REG_ONE], 1'(k))) <<< 32)
                    + (SUM_W'(lx1_ff[k]) <<< 16)
                    + (SUM_W'(ly1_ff[k]) <<< 16);
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         qxy2_ff <= qxy2_in;
         qxx2_ff <= qxx2_in;
         qyy2_ff <= qyy2_in;
         lin2_ff <= lin2_in;
      end
   end

   // Stage 3: full sum plus one half of the output step.
   logic signed [SUM_W-1:0] sum3_in [NUM_LANES];
   logic signed [SUM_W-1:0] sum3_ff [NUM_LANES];

   always_comb begin
      for (int k = 0; k < NUM_LANES; k++) begin
         sum3_in[k] = lin2_ff[k]
                    + SUM_W'(qxy2_ff[k])
                    + SUM_W'(qxx2_ff[k])
                    + SUM_W'(qyy2_ff[k])
                    + (SUM_W'(1) <<< (FRAC_SHIFT - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (s3_adv) begin
         sum3_ff <= sum3_in;
      end
   end

   // Stage 4: drop the fraction (floor), saturate and register the result.
   logic [RS_W-1:0]  rnd4     [NUM_LANES];
   logic [SRC_W-1:0] src4_in  [NUM_LANES];
   logic [NUM_LANES-1:0] sat4;
   logic [SRC_W-1:0] src4_ff  [NUM_LANES];
   logic             ovf4_ff;

   always_comb begin
      for (int k = 0; k < NUM_LANES; k++) begin
         rnd4[k] = sum3_ff[k][SUM_W-1:FRAC_SHIFT];
         // In range when every bit above the result's sign copies it.
         sat4[k] = !((&rnd4[k][RS_W-1:SRC_W-1]) || !(|rnd4[k][RS_W-1:SRC_W-1]));
         if (!sat4[k]) begin
            src4_in[k] = rnd4[k][SRC_W-1:0];
         end else if (rnd4[k][RS_W-1]) begin
            src4_in[k] = SAT_MIN;
         end else begin
            src4_in[k] = SAT_MAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s4_adv) begin
         src4_ff <= src4_in;
         ovf4_ff <= |sat4;
      end
   end

   assign rsp_tvalid = s4_valid_ff;
   assign rsp_tdata  = {src4_ff[1], src4_ff[0]};
   assign rsp_tuser  = ovf4_ff;

`ifndef SYNTHESIS
   // With no result waiting, the pipeline always takes a new transaction.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled while the result register is empty");

   // An accepted transaction occupies the first stage on the next edge.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> s1_valid_ff)
      else $error("accepted transaction did not enter stage one");

   // The overflow flag goes out only with a saturated coordinate.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |->
         (rsp_tdata[31:0] == SAT_MAX) || (rsp_tdata[31:0] == SAT_MIN) ||
         (rsp_tdata[63:32] == SAT_MAX) || (rsp_tdata[63:32] == SAT_MIN))
      else $error("overflow flag without a saturated coordinate");
`endif

endmodule : quadratic_polynomial_coord_warp_top

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the quadratic polynomial coordinate warp.
`timescale 1ns / 1ps

module testbench;
   import qpcw_pkg::*;

   localparam int HALF_PERIOD     = 2;
   localparam int RESET_CYCLES    = 5;
   localparam int LATENCY         = 4;
   localparam int DRAIN_PAUSE     = LATENCY + 4;
   localparam int END_PAUSE       = 4 * LATENCY;
   localparam int LIMIT_CYCLES    = 400000;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 138;
   localparam int HOLD_AT         = 150;
   localparam int HOLD_CYCLES     = 64;
   localparam int MAX_REPORTS     = 10;

   // Exact sum in units of 2^-40, well above the widest term.
   localparam int ACC_W      = 80;
   localparam int LIN_SHIFT  = 16;
   localparam logic signed [ACC_W-1:0] HALF_LSB = 80'sd2147483648;
   localparam logic signed [ACC_W-1:0] ACC_MAX  = 80'sd2147483647;
   localparam logic signed [ACC_W-1:0] ACC_MIN  = -80'sd2147483648;

   // Register indexes outside the six coefficient pairs.
   localparam logic [CSR_IDX_W-1:0] UNUSED_INDEX_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] UNUSED_INDEX_HI = 3'd7;

   typedef enum int {ROW_ITEM, ROW_CSR} row_kind_type;
   typedef enum int {STYLE_WARP, STYLE_WIDE, STYLE_PEAK, STYLE_FLOOR, STYLE_MIXED} coef_style_type;

   typedef struct packed {
      logic [SRC_W-1:0] sx;
      logic [SRC_W-1:0] sy;
      logic             ovf;
   } source_pair_type;

   typedef struct {
      logic [PIXEL_W-1:0] px;
      logic [PIXEL_W-1:0] py;
      source_pair_type    val;
   } pending_source_type;

   typedef struct {
      bit              typed;
      source_pair_type val;
   } known_source_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] wdata;
      logic [PIXEL_W-1:0]    px;
      logic [PIXEL_W-1:0]    py;
      bit                    typed;
      source_pair_type       val;
   } directed_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [11:0] pixel_x, [23:12] pixel_y
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [31:0] source_x, [63:32] source_y
   logic                  rsp_tuser;        // [0] overflow
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic [CSR_DATA_W-1:0] coef_regs [NUM_REGS];
   pending_source_type    pending_sources [$];
   known_source_type      typed_sources [$];
   directed_row_type      directed [$];
   int                    failures = 0;
   int                    reported = 0;
   int                    items_taken = 0;
   int                    cycle_count = 0;
   bit                    calm = 1'b0;

   quadratic_polynomial_coord_warp_top #(.COORD_BITS(PIXEL_W)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // One axis of the warp: exact sum, round half up to 8 fraction bits, saturate.
   function automatic void eval_axis(input int lane, input logic [PIXEL_W-1:0] px,
                                     input logic [PIXEL_W-1:0] py,
                                     output logic [SRC_W-1:0] src, output logic clipped);
      logic signed [COEF_W-1:0] c;
      logic signed [ACC_W-1:0]  term [NUM_REGS];
      logic signed [ACC_W-1:0]  xv, yv, acc, rounded;
      for (int i = 0; i < NUM_REGS; i++) begin
         c = coef_regs[i][lane*COEF_W +: COEF_W];
         term[i] = c;
      end
      xv = ACC_W'(px);
      yv = ACC_W'(py);
      acc = (term[REG_ONE] <<< FRAC_SHIFT)
          + ((term[REG_X] * xv + term[REG_Y] * yv) <<< LIN_SHIFT)
          + term[REG_XY] * xv * yv + term[REG_XX] * xv * xv + term[REG_YY] * yv * yv;
      rounded = (acc + HALF_LSB) >>> FRAC_SHIFT;
      clipped = 1'b0;
      if (rounded > ACC_MAX) begin
         src = SAT_MAX;
         clipped = 1'b1;
      end else if (rounded < ACC_MIN) begin
         src = SAT_MIN;
         clipped = 1'b1;
      end else begin
         src = rounded[SRC_W-1:0];
      end
   endfunction

   function automatic source_pair_type predict_source(input logic [PIXEL_W-1:0] px,
                                                      input logic [PIXEL_W-1:0] py);
      source_pair_type res;
      logic            clip_x, clip_y;
      eval_axis(0, px, py, res.sx, clip_x);
      eval_axis(1, px, py, res.sy, clip_y);
      res.ovf = clip_x | clip_y;
      return res;
   endfunction

   task automatic flag_failure(input string text);
      failures++;
      if (reported < MAX_REPORTS) begin
         reported++;
         $display("%s", text);
      end
   endtask

   // Track the coefficients, predict each accepted request and check each result.
   always @(posedge clock) begin
      source_pair_type    got;
      pending_source_type want;
      known_source_type   known;
      if (reset) begin
         coef_regs[REG_ONE] = RESET_ONE;
         coef_regs[REG_X]   = RESET_X;
         coef_regs[REG_Y]   = RESET_Y;
         coef_regs[REG_XY]  = RESET_Q;
         coef_regs[REG_XX]  = RESET_Q;
         coef_regs[REG_YY]  = RESET_Q;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.sx  = rsp_tdata[SRC_W-1:0];
            got.sy  = rsp_tdata[RSP_DATA_W-1:SRC_W];
            got.ovf = rsp_tuser;
            if (pending_sources.size() == 0) begin
               flag_failure($sformatf("unexpected result sx=%h sy=%h ovf=%b",
                                      got.sx, got.sy, got.ovf));
            end else begin
               want = pending_sources.pop_front();
               if (got.sx !== want.val.sx || got.sy !== want.val.sy ||
                   got.ovf !== want.val.ovf)
                  flag_failure($sformatf(
                     "mismatch x=%0d y=%0d: expected sx=%h sy=%h ovf=%b, got sx=%h sy=%h ovf=%b",
                     want.px, want.py, want.val.sx, want.val.sy, want.val.ovf,
                     got.sx, got.sy, got.ovf));
            end
         end
         if (req_tvalid && req_tready) begin
            known = typed_sources.pop_front();
            want.px = req_tdata[PIXEL_W-1:0];
            want.py = req_tdata[REQ_DATA_W-1:PIXEL_W];
            want.val = known.typed ? known.val : predict_source(want.px, want.py);
            pending_sources.insert(pending_sources.size(), want);
            items_taken++;
         end
         if (csr_we && csr_index < NUM_REGS)
            coef_regs[csr_index] = csr_wdata;
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("[quadratic_polynomial_coord_warp_top] ERROR");
         $finish;
      end
   end

   // Result side: short random stalls, one long hold to back the pipeline up.
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && items_taken >= HOLD_AT) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // Offer one request and hold it until the block takes it.
   task automatic offer_pixel(input logic [PIXEL_W-1:0] px, input logic [PIXEL_W-1:0] py,
                              input bit typed, input source_pair_type val);
      known_source_type known;
      known.typed = typed;
      known.val   = val;
      typed_sources.insert(typed_sources.size(), known);
      req_tvalid <= 1'b1;
      req_tdata  <= {py, px};
      do @(posedge clock); while (!req_tready);
   endtask

   // Let every outstanding transaction come back before touching the registers.
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_sources.size() != 0 || typed_sources.size() != 0) @(posedge clock);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   // Drive one register write; the caller drops the write enable after the last one.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   function automatic void append_row(input directed_row_type row);
      directed.insert(directed.size(), row);
   endfunction

   function automatic directed_row_type csr_row(input logic [CSR_IDX_W-1:0] idx,
                                                input logic [CSR_DATA_W-1:0] data);
      directed_row_type row;
      row = '{ROW_CSR, idx, data, '0, '0, 1'b0, '0};
      return row;
   endfunction

   function automatic directed_row_type item_row(input logic [PIXEL_W-1:0] px,
                                                 input logic [PIXEL_W-1:0] py, input bit typed,
                                                 input logic [SRC_W-1:0] sx,
                                                 input logic [SRC_W-1:0] sy, input logic ovf);
      directed_row_type row;
      row = '{ROW_ITEM, '0, '0, px, py, typed, '{sx, sy, ovf}};
      return row;
   endfunction

   function automatic logic [COEF_W-1:0] jitter(input int unsigned span);
      return COEF_W'($urandom_range(0, 2 * span) - span);
   endfunction

   // One 32-bit coefficient word of the given style.
   function automatic logic [COEF_W-1:0] draw_word(input coef_style_type style,
                                                   input reg_index_type idx, input int lane);
      case (style)
         STYLE_PEAK:  return 32'h7FFF_FFFF;
         STYLE_FLOOR: return 32'h8000_0000;
         STYLE_WIDE:  return $urandom;
         STYLE_MIXED: begin
            case ($urandom_range(0, 4))
               0:       return '0;
               1:       return '1;
               2:       return 32'h7FFF_FFFF;
               3:       return 32'h8000_0000;
               default: return $urandom;
            endcase
         end
         default: begin
            // Mild lens-like distortion around the identity mapping.
            case (idx)
               REG_ONE: return jitter(1 << 20);
               REG_X:   return (lane == 0) ? 32'h0100_0000 + jitter(1 << 20) : jitter(1 << 18);
               REG_Y:   return (lane == 1) ? 32'h0100_0000 + jitter(1 << 20) : jitter(1 << 18);
               default: return jitter(1 << 12);
            endcase
         end
      endcase
   endfunction

   // Coordinates lean toward the edges of the image now and then.
   function automatic logic [PIXEL_W-1:0] draw_coord();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return PIXEL_W'($urandom);
      endcase
   endfunction

   // Main sequence: reset, directed table, then random phases.
   initial begin
      coef_style_type     phase_style [PHASES];
      reg_index_type      idx;
      logic [COEF_W-1:0]  word_x, word_y;
      logic [PIXEL_W-1:0] px, py;

      phase_style = '{STYLE_WARP, STYLE_WIDE, STYLE_PEAK, STYLE_WARP,
                      STYLE_FLOOR, STYLE_MIXED, STYLE_WIDE, STYLE_WARP};

      // Identity mapping straight out of reset.
      append_row(item_row(12'd0, 12'd0, 1, 32'h0, 32'h0, 1'b0));
      append_row(item_row(12'hFFF, 12'hFFF, 1, 32'h000F_FF00, 32'h000F_FF00, 1'b0));
      append_row(item_row(12'hFFF, 12'd0, 1, 32'h000F_FF00, 32'h0, 1'b0));
      append_row(item_row(12'd0, 12'hFFF, 1, 32'h0, 32'h000F_FF00, 1'b0));
      append_row(item_row(12'hAAA, 12'h555, 1, 32'h000A_AA00, 32'h0005_5500, 1'b0));
      // Offsets at the rails: the row offset saturates upward as soon as y moves.
      append_row(csr_row(REG_ONE, 64'h7FFF_FFFF_8000_0000));
      append_row(item_row(12'd0, 12'd0, 1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
      append_row(item_row(12'd0, 12'd1, 1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
      append_row(item_row(12'hFFF, 12'd0, 1, 32'h800F_FF00, 32'h7FFF_FFFF, 1'b0));
      // A negative column gain pushes the column below the lower rail.
      append_row(csr_row(REG_X, 64'h0000_0000_FF00_0000));
      append_row(item_row(12'd1, 12'd0, 1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
      append_row(item_row(12'd0, 12'd0, 1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
      // Exact halves round toward plus infinity.
      append_row(csr_row(REG_ONE, 64'h0));
      append_row(csr_row(REG_X, RESET_X));
      append_row(csr_row(REG_XX, 64'h0000_0000_0000_8000));
      append_row(item_row(12'd256, 12'd0, 1, 32'h0001_0001, 32'h0, 1'b0));
      append_row(csr_row(REG_XX, 64'h0000_0000_FFFF_8000));
      append_row(item_row(12'd256, 12'd0, 1, 32'h0001_0000, 32'h0, 1'b0));
      // Writes to indexes past the last register leave the mapping alone.
      append_row(csr_row(UNUSED_INDEX_LO, '1));
      append_row(csr_row(UNUSED_INDEX_HI, '1));
      append_row(item_row(12'd256, 12'd0, 1, 32'h0001_0000, 32'h0, 1'b0));
      // Extreme quadratic and linear terms, checked by prediction.
      append_row(csr_row(REG_XY, 64'h8000_0000_7FFF_FFFF));
      append_row(csr_row(REG_YY, 64'h7FFF_FFFF_8000_0000));
      append_row(csr_row(REG_XX, 64'h8000_0000_8000_0000));
      append_row(csr_row(REG_Y, 64'h7FFF_FFFF_8000_0000));
      append_row(item_row(12'hFFF, 12'hFFF, 0, '0, '0, 1'b0));
      append_row(item_row(12'hFFF, 12'd0, 0, '0, '0, 1'b0));
      append_row(item_row(12'd0, 12'hFFF, 0, '0, '0, 1'b0));
      append_row(item_row(12'd1, 12'd1, 0, '0, '0, 1'b0));
      append_row(item_row(12'd2048, 12'd2048, 0, '0, '0, 1'b0));
      append_row(csr_row(REG_ONE, '1));
      append_row(item_row(12'hFFF, 12'hFFF, 0, '0, '0, 1'b0));
      append_row(item_row(12'd0, 12'd0, 0, '0, '0, 1'b0));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].kind == ROW_CSR) begin
            drain_pipeline();
            write_reg(directed[i].index, directed[i].wdata);
            csr_we <= 1'b0;
         end else begin
            offer_pixel(directed[i].px, directed[i].py, directed[i].typed, directed[i].val);
         end
      end

      // Random phases, each under a fresh set of all six coefficient pairs.
      for (int p = 0; p < PHASES; p++) begin
         drain_pipeline();
         calm = (p == PHASES - 1);
         for (int r = 0; r < NUM_REGS; r++) begin
            idx    = reg_index_type'(r);
            word_x = draw_word(phase_style[p], idx, 0);
            word_y = draw_word(phase_style[p], idx, 1);
            write_reg(idx, {word_y, word_x});
         end
         write_reg($urandom_range(0, 1) ? UNUSED_INDEX_HI : UNUSED_INDEX_LO,
                   {$urandom, $urandom});
         csr_we <= 1'b0;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (!calm && $urandom_range(0, 3) == 0) begin
               req_tvalid <= 1'b0;
               repeat ($urandom_range(1, 3)) @(posedge clock);
            end
            px = draw_coord();
            py = draw_coord();
            offer_pixel(px, py, 1'b0, '0);
         end
      end

      // Wind down and give any stray result time to show up.
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_sources.size() != 0) @(posedge clock);
      repeat (END_PAUSE) @(posedge clock);

      if (failures == 0 && pending_sources.size() == 0) begin
         $display("[quadratic_polynomial_coord_warp_top] OK");
      end else begin
         $display("[quadratic_polynomial_coord_warp_top] ERROR");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/qpcw_pkg.sv
rtl/core/quadratic_polynomial_coord_warp_top.sv
sim/testbench.sv
